// File: design/sliding_window_median_macros.svh
// ------------------------------------------------------------------------
// Sliding window median: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/swm_pkg.sv
// ------------------------------------------------------------------------
// Sliding window median: package
// Sample type, defaults and the word types passed along the cell row.
// ------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int WINDOW_DEF = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// cell contents as seen by its left neighbor
	typedef struct packed {
		logic    valid;
		logic    gx;      // entry is above the new sample (or empty)
		sample_t value;
	} swm_raw_t;

	// cell contents after the oldest sample is dropped, seen by its right neighbor
	typedef struct packed {
		logic    valid;
		logic    gx;
		sample_t value;
	} swm_fwd_t;

endpackage

// File: design/swm_sample_if.sv
// ------------------------------------------------------------------------
// Sliding window median: sample channel
// Valid/ready channel carrying one input sample word.
// ------------------------------------------------------------------------
interface swm_sample_if import swm_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// File: design/swm_median_if.sv
// ------------------------------------------------------------------------
// Sliding window median: median channel
// Valid/ready channel carrying one result median word.
// ------------------------------------------------------------------------
interface swm_median_if import swm_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

// File: design/swm_ram.sv
// ------------------------------------------------------------------------
// Sliding window median: generic RAM
// One write port, one read port with registered, read-first data.
// ------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/swm_cell.sv
// ------------------------------------------------------------------------
// Sliding window median: sorted cell
// One entry of the sorted window; drops the oldest and inserts the new
// sample using only its own and its neighbors' contents.
// ------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     upd,
	input  logic     full,
	input  sample_t  x,
	input  sample_t  oldest,
	input  swm_fwd_t left,
	input  swm_raw_t right,
	output swm_raw_t own,
	output swm_fwd_t fwd
);

	logic    valid_q;
	sample_t value_q;
	logic    below_del;
	logic    next_valid;
	sample_t next_value;

	always_comb begin
		own.valid = valid_q;
		own.value = value_q;
		own.gx    = !valid_q || (value_q > x);

		// entries below the first copy of the oldest sample keep their place
		below_del = !full || (valid_q && (value_q < oldest));

		fwd = below_del ? own : right;

		// own or right neighbor's entry, new sample, or left neighbor's entry
		if (!fwd.gx) begin
			next_valid = fwd.valid;
			next_value = fwd.value;
		end else if (!left.gx) begin
			next_valid = 1'b1;
			next_value = x;
		end else begin
			next_valid = left.valid;
			next_value = left.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			value_q <= next_value;
		end
	end

endmodule

// File: design/sliding_window_median.sv
// An accepted sample is registered (s1), updates the row (s2), then fills the median word.
// One sample word per cycle when not stalled; each sorted-row cell updates once per word.
// The oldest sample comes from the ring RAM's registered read, loaded along with x_s1.
// Reset empties the window (all cell valid bits and the fill count clear at once).
// The ring RAM is not cleared; its read data is used only once the window is full.
// Backpressure on the median channel stalls the whole pipeline.
// ------------------------------------------------------------------------
// Sliding window median: top level
// Running lower median over the last WINDOW samples, kept as a row of
// sorted cells beside a ring of samples in arrival order.
// ------------------------------------------------------------------------
module sliding_window_median import swm_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input logic          clk,
	input logic          arst_n,
	swm_sample_if.sink   samples,
	swm_median_if.source medians
);

	`include "sliding_window_median_macros.svh"

	localparam int IDX_W = $clog2(WINDOW);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] MED_FULL = IDX_W'((WINDOW - 1) / 2);

	// pipeline control
	logic    en;
	logic    accept;
	logic    upd;
	logic    full;

	// ring of samples in arrival order
	logic [IDX_W-1:0] wpos_q;
	sample_t          oldest_s1;
	logic [SAMPLE_W-1:0] ring_rdata;

	// update stage
	logic    valid_s1;
	sample_t x_s1;

	// median select stage
	logic             valid_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [CNT_W-1:0] count_q;

	// output word
	logic    out_valid_q;
	sample_t out_median_q;

	// cell row
	swm_raw_t          raw [WINDOW];
	swm_fwd_t          fwd [WINDOW];
	logic [WINDOW-1:0] valid_vec;
	sample_t           cell_val [WINDOW];

	// advance everything whenever the output word is free or being taken
	assign en             = !out_valid_q || medians.ready;
	assign samples.ready  = en;
	assign accept         = samples.valid && en;
	assign upd            = en && valid_s1;
	assign full           = valid_vec[WINDOW-1];
	assign medians.valid  = out_valid_q;
	assign medians.median = out_median_q;

	// read the slot about to be overwritten: that is the oldest sample
	swm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(wpos_q),
		.wdata(samples.sample),
		.re   (accept),
		.raddr(wpos_q),
		.rdata(ring_rdata)
	);

	assign oldest_s1 = sample_t'(ring_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (accept) begin
				wpos_q <= wpos_q + 1'b1;
			end
			if (valid_s1 && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= samples.sample;
		end
		// rank of the lower median once this word is in: ceil(k/2) - 1
		if (upd) begin
			idx_s2 <= full ? MED_FULL : IDX_W'(count_q >> 1);
		end
		if (en && valid_s2) begin
			out_median_q <= cell_val[idx_s2];
		end
	end

	// row of sorted cells, smallest at index 0
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		swm_fwd_t left_in;
		swm_raw_t right_in;

		if (i == 0) begin : g_first
			assign left_in = '{valid: 1'b1, gx: 1'b0, value: '0};
		end else begin : g_mid_l
			assign left_in = fwd[i-1];
		end

		if (i == WINDOW - 1) begin : g_last
			assign right_in = '{valid: 1'b0, gx: 1'b1, value: '0};
		end else begin : g_mid_r
			assign right_in = raw[i+1];
		end

		swm_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.upd   (upd),
			.full  (full),
			.x     (x_s1),
			.oldest(oldest_s1),
			.left  (left_in),
			.right (right_in),
			.own   (raw[i]),
			.fwd   (fwd[i])
		);

		assign valid_vec[i] = raw[i].valid;
		assign cell_val[i]  = raw[i].value;
	end

	// valid cells always form a solid run from index 0
	`SWM_ASSERT_NOW(a_valid_solid, 1'b1, ((valid_vec + WINDOW'(1)) & valid_vec) == '0, "cell valid bits not contiguous")
	// fill count tracks the number of valid cells
	`SWM_ASSERT_NOW(a_count_match, 1'b1, count_q == CNT_W'($countones(valid_vec)), "fill count differs from valid cells")
	// an update into a window that is not full grows it by one
	`SWM_ASSERT_NEXT(a_fill_grow, upd && !full, $countones(valid_vec) == $countones($past(valid_vec)) + 1, "window did not grow by one")
	// without an update the row holds
	`SWM_ASSERT_NEXT(a_row_hold, !upd, $stable(valid_vec), "cell row changed without an update")

endmodule

// File: test/sliding_window_median_tb.sv
// ------------------------------------------------------------------------
// Sliding window median: testbench
// Streams signed sample words through the block and checks every median
// word against a predictor that keeps its own ring and sorted window.
// Both channels idle at random; one long output stall and a few drain
// pauses push the block into backpressure and back out of it.
// ------------------------------------------------------------------------
module sliding_window_median_tb import swm_pkg::*;;

	localparam int          WIN          = WINDOW_DEF;
	localparam int          MAX_GAP      = 17;
	localparam int          LONG_HOLD    = 60;
	localparam int          SETTLE       = 8;
	localparam int          PHASES       = 11;
	localparam int          PHASE_WORDS  = 50;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam sample_t     TOP          = 32'sh7fffffff;
	localparam sample_t     BOTTOM       = 32'sh80000000;

	// content profile of one random phase
	typedef enum int {SPREAD, CLUSTER, RAMP, EXTREME} profile_t;

	// one planned sample word, the idle cycles after it, and whether to wait
	// for every outstanding median before offering it
	typedef struct {
		sample_t     value;
		int unsigned gap;
		bit          drain;
	} word_plan_t;

	logic clk;
	logic arst_n;

	swm_sample_if samples_ch ();
	swm_median_if medians_ch ();

	sliding_window_median #(.WINDOW(WIN)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.medians (medians_ch)
	);

	word_plan_t  sample_plan [$];
	sample_t     median_due [$];

	// predictor state: samples in arrival order plus the same samples sorted
	sample_t     arrival [WIN];
	sample_t     held_sorted [$];
	int          next_slot;

	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned drains;
	int unsigned hold_at;
	bit          long_hold_done;

	// Work out the median word that one accepted sample must produce.
	function automatic sample_t next_median(sample_t s);
		int at;
		bit gone;
		gone = 1'b0;
		// drop exactly one copy of the departing sample once the window is full
		if (held_sorted.size() == WIN) begin
			for (at = 0; at < held_sorted.size() && !gone; at++) begin
				if (held_sorted[at] == arrival[next_slot]) begin
					held_sorted.delete(at);
					gone = 1'b1;
				end
			end
		end
		at = held_sorted.size();
		while (at > 0 && held_sorted[at-1] > s)
			at--;
		held_sorted.insert(at, s);
		arrival[next_slot] = s;
		next_slot = (next_slot + 1) % WIN;
		// lower median: the ceil(k/2)-th smallest
		return held_sorted[(held_sorted.size() + 1) / 2 - 1];
	endfunction

	function automatic void plan_word(sample_t value, int unsigned gap, bit drain);
		word_plan_t w;
		w.value = value;
		w.gap   = gap;
		w.drain = drain;
		sample_plan.push_back(w);
	endfunction

	// Draw one sample word for the given profile; step is the index in the phase.
	function automatic sample_t draw_sample(profile_t p, int step, sample_t base,
			sample_t slope);
		sample_t v;
		case (p)
			SPREAD: begin
				v = $urandom;
			end
			CLUSTER: begin
				// few distinct values, so equal samples enter and leave often
				v = sample_t'($urandom_range(0, 6)) - 3;
			end
			RAMP: begin
				v = base + slope * step;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: v = TOP;
					1: v = BOTTOM;
					2: v = TOP - sample_t'($urandom_range(0, 3));
					3: v = BOTTOM + sample_t'($urandom_range(0, 3));
					4: v = '0;
					default: v = -1;
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles: %0d samples in, %0d medians out",
				cycles, words_in, words_out);
			$display("Some tests failed");
			$finish;
		end
	end

	// Sample driver: offer the next planned word once the gap after the last
	// one has run out; hold a word that carries a drain mark until nothing
	// is outstanding on the median side.
	always @(posedge clk or negedge arst_n) begin : drive_samples
		logic       offer;
		word_plan_t nxt;
		if (!arst_n) begin
			samples_ch.valid  <= 1'b0;
			samples_ch.sample <= '0;
			gap_left          <= 0;
		end else begin
			offer = samples_ch.valid;
			if (samples_ch.valid && samples_ch.ready) begin
				median_due.push_back(next_median(samples_ch.sample));
				words_in++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (sample_plan.size() > 0 &&
						!(sample_plan[0].drain && median_due.size() > 0)) begin
					nxt = sample_plan.pop_front();
					samples_ch.sample <= nxt.value;
					gap_left          <= nxt.gap;
					offer = 1'b1;
				end
			end
			// single update of valid per edge keeps back-to-back words high
			samples_ch.valid <= offer;
		end
	end

	// Median monitor: check each accepted word against the oldest expectation,
	// then draw how long to stall before taking the next one.
	always @(posedge clk or negedge arst_n) begin : take_medians
		int unsigned hold;
		sample_t     want;
		if (!arst_n) begin
			medians_ch.ready <= 1'b0;
			stall_left       <= 0;
		end else begin
			hold = stall_left;
			if (medians_ch.valid && medians_ch.ready) begin
				if (median_due.size() == 0) begin
					$error("median word %0d arrived with none expected (median %0d)",
						words_out, medians_ch.median);
					mismatches++;
				end else begin
					want = median_due.pop_front();
					if (medians_ch.median !== want) begin
						$error("median word %0d: median expected %0d, actual %0d",
							words_out, want, medians_ch.median);
						mismatches++;
					end
				end
				words_out++;
				if (!long_hold_done && hold_at != 0 && words_out >= hold_at) begin
					// stall long enough for the sender to back up into the block
					hold = LONG_HOLD;
					long_hold_done = 1'b1;
				end else if ((words_out / 96) % 3 == 1) begin
					hold = 0;
				end else begin
					hold = $urandom_range(0, MAX_GAP);
				end
			end else if (hold > 0) begin
				hold = hold - 1;
			end
			stall_left       <= hold;
			medians_ch.ready <= (hold == 0);
		end
	end

	initial begin : run_test
		sample_t  directed [] = '{TOP, BOTTOM, 0, -1, 1, TOP, BOTTOM,
			7, 7, 7, 7, 7, -7, -7, 32'sh55555555, 32'shaaaaaaaa,
			3, 3, 3, 100, -100, 7, 7, TOP};
		profile_t    prof;
		sample_t     base;
		sample_t     slope;
		bit          burst;
		int          ph;
		int          k;
		int unsigned planned;

		// drive every input to a known value before anything else happens
		arst_n            = 1'b0;
		samples_ch.valid  = 1'b0;
		samples_ch.sample = '0;
		medians_ch.ready  = 1'b0;
		next_slot         = 0;
		cycles            = 0;
		words_in          = 0;
		words_out         = 0;
		mismatches        = 0;
		drains            = 0;
		hold_at           = 0;
		long_hold_done    = 1'b0;

		// Directed part: first sample alone, both extremes, runs of equal
		// samples, and enough words to wrap the window so the oldest sample
		// starts leaving, equal values included.
		foreach (directed[i])
			plan_word(directed[i], $urandom_range(0, MAX_GAP), 1'b0);

		// Random part: phases of differing content; two phases stream with no
		// gaps, and the long output stall lands inside the first of them.
		for (ph = 0; ph < PHASES; ph++) begin
			prof  = profile_t'(ph % 4);
			burst = (ph == 2 || ph == 9);
			base  = $urandom;
			slope = sample_t'($urandom_range(0, 4000)) - 2000;
			if (ph == 2)
				hold_at = sample_plan.size() + 10;
			for (k = 0; k < PHASE_WORDS; k++) begin
				// drain before the random part and before two later phases
				plan_word(draw_sample(prof, k, base, slope),
					burst ? 0 : $urandom_range(0, MAX_GAP),
					k == 0 && (ph == 0 || ph == 5 || ph == 8));
				if (k == 0 && (ph == 0 || ph == 5 || ph == 8))
					drains++;
			end
		end
		planned = sample_plan.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all words to go in, then for every median to come back
		while (words_in < planned)
			@(posedge clk);
		while (median_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d samples and %0d medians over a %0d-deep window,",
			words_in, words_out, WIN);
		$display("with %0d drain pauses and a %0d-cycle output stall; %0d mismatches",
			drains, LONG_HOLD, mismatches);
		if (mismatches == 0 && median_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/swm_pkg.sv
design/swm_sample_if.sv
design/swm_median_if.sv
design/swm_ram.sv
design/swm_cell.sv
design/sliding_window_median.sv
test/sliding_window_median_tb.sv
